### sv/lzw_pkg.sv
// shared types and constants of the lzw stream decoder
package lzw_pkg;

	localparam int CODE_W = 12;

	localparam logic [CODE_W-1:0] CODE_CLEAR  = 12'd256;
	localparam logic [CODE_W-1:0] CODE_END    = 12'd257;
	localparam logic [CODE_W-1:0] FIRST_ENTRY = 12'd258;

	localparam logic [CODE_W:0] EDGE_W10 = 13'd511;
	localparam logic [CODE_W:0] EDGE_W11 = 13'd1023;
	localparam logic [CODE_W:0] EDGE_W12 = 13'd2047;

	localparam logic [3:0] WIDTH_MIN = 4'd9;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_REFUSED = 2'd1;
	localparam logic [1:0] STAT_BAD     = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEADP,
		ST_LEADC,
		ST_UNWIND,
		ST_TAIL,
		ST_POP
	} dec_state_t;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [7:0]        suffix;
		logic [7:0]        first;
	} dict_entry_t;

endpackage

### sv/lzw_dict.sv
// dictionary memory: prefix, suffix and lead byte per entry, with write bypass
module lzw_dict #(
	parameter int DEPTH = 3840,
	parameter int AW = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  lzw_pkg::dict_entry_t wdata,
	input  logic [AW-1:0]        raddr,
	output lzw_pkg::dict_entry_t rdata
);
	import lzw_pkg::*;

	dict_entry_t mem [DEPTH];
	dict_entry_t rd_q;
	dict_entry_t wd_q;
	logic        byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
		wd_q <= wdata;
	end

	// read of the entry written in the same cycle returns the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? wd_q : rd_q;

endmodule

### sv/lzw_stack.sv
// unwind stack memory for one expanded string
module lzw_stack #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import lzw_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

### sv/lzw_stream_decoder.sv
// top level of the lzw stream decoder: code cutter, control and memories
// Usage:
// Input beats carry mode and in_byte. mode 0 supplies a compressed byte, mode 1
// pulls the next decoded byte. Every input beat yields exactly one result beat
// with out_byte, out_valid, string_last, data_ended and status.
// A supplied byte is refused (status 1) while decoded bytes are still pending.
// Result path: the result of a supplied byte or of an empty pull is registered at
// the accepting edge and shows in the next cycle; a pull reads the stack memory
// at acceptance, passes through ST_POP, and its result is registered there.
// Busy states: a pull passes through ST_POP. A byte whose code adds a dictionary
// entry passes through ST_LEADP and ST_LEADC when that code is a literal, and
// through these, ST_UNWIND for each link of the prefix chain and ST_TAIL when
// it is an entry code (the prefix chain is walked one dictionary read a cycle).
// Other bytes are taken in ST_IDLE alone.
// One result register sits at the output; in_stall rises while it is full and
// res_stall holds it, and while an item is at work.
// Reset clears all control state, sets early_change to 1 and code width to 9.
// The memories need no clearing pass. cfg_wen writes early_change; write it
// only while idle.
module lzw_stream_decoder #(
	parameter int MAX_CODES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       string_last,
	output logic       data_ended,
	output logic [1:0] status
);
	import lzw_pkg::*;

	localparam int AW = $clog2(MAX_CODES);
	localparam int TABLE_DEPTH = MAX_CODES - 256;
	localparam logic [AW-1:0] FULL_AT = AW'(MAX_CODES - 258);

	dec_state_t state_q, state_n;

	logic [23:0]   acc_q;
	logic [4:0]    bits_q;
	logic [3:0]    width_q;
	logic [AW-1:0] prev_q;
	logic [AW-1:0] count_q;
	logic          end_q;
	logic [1:0]    err_q;
	logic [AW:0]   depth_q;
	logic          early_q;
	logic [AW-1:0] code_q;
	logic [7:0]    leadp_q;
	logic [AW-1:0] chain_q;

	logic          rv_q;
	logic [7:0]    ob_q;
	logic          ov_q;
	logic          last_q;
	logic          de_q;
	logic [1:0]    st_q;

	// accept side
	logic        go, absorb, pull, refuse;
	logic [23:0] acc_n, shifted;
	logic [4:0]  bits_n, shift;
	logic        cut;
	logic [AW-1:0] code, idx, mask;
	logic        take, prev_clear, is_entry, bad, full;
	logic        lit_push, to_leadp;
	logic        end_n;
	logic [1:0]  err_n;

	// memory ports
	logic          d_we;
	logic [AW-1:0] d_waddr, d_raddr;
	dict_entry_t   d_wdata, d_rdata;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [7:0]    s_wdata, s_rdata;

	logic [7:0]  lead_prev, add_c;
	logic [AW:0] new_code, edge_val;
	logic        chain_more;

	assign in_stall = (state_q != ST_IDLE) || (rv_q && res_stall);
	assign go       = in_valid && !in_stall;
	assign absorb   = go && !mode && (depth_q == '0);
	assign refuse   = go && !mode && (depth_q != '0);
	assign pull     = go && mode && (depth_q != '0);

	assign acc_n   = {acc_q[15:0], in_byte};
	assign bits_n  = bits_q + 5'd8;
	assign cut     = bits_n >= {1'b0, width_q};
	assign shift   = bits_n - {1'b0, width_q};
	assign shifted = acc_n >> shift;
	assign mask    = {AW{1'b1}} >> (4'(AW) - width_q);
	assign code    = shifted[AW-1:0] & mask;

	assign take       = absorb && cut && !end_q && (err_q == STAT_OK);
	assign prev_clear = prev_q == CODE_CLEAR;
	assign is_entry   = code >= FIRST_ENTRY;
	assign idx        = code - FIRST_ENTRY;
	assign bad        = is_entry && (prev_clear || (idx > count_q));
	assign full       = !prev_clear && (count_q >= FULL_AT);

	always_comb begin
		end_n    = end_q;
		err_n    = err_q;
		lit_push = 1'b0;
		to_leadp = 1'b0;
		if (take && code != CODE_CLEAR) begin
			if (code == CODE_END) begin
				end_n = 1'b1;
			end else if (bad) begin
				err_n = STAT_BAD;
			end else if (full) begin
				err_n = STAT_FULL;
			end else if (prev_clear) begin
				lit_push = 1'b1;
			end else begin
				to_leadp = 1'b1;
			end
		end
	end

	assign lead_prev  = (prev_q < 12'd256) ? prev_q[7:0] : d_rdata.first;
	assign add_c      = (code_q < 12'd256) ? code_q[7:0] :
	                    ((code_q - FIRST_ENTRY) == count_q) ? leadp_q : d_rdata.first;
	assign new_code   = {1'b0, FIRST_ENTRY} + {1'b0, count_q};
	assign edge_val   = new_code + {{AW{1'b0}}, early_q};
	assign chain_more = d_rdata.prefix >= FIRST_ENTRY;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pull) begin
					state_n = ST_POP;
				end else if (to_leadp) begin
					state_n = ST_LEADP;
				end
			end
			ST_LEADP: state_n = ST_LEADC;
			ST_LEADC: state_n = (code_q >= FIRST_ENTRY) ? ST_UNWIND : ST_IDLE;
			ST_UNWIND: state_n = chain_more ? ST_UNWIND : ST_TAIL;
			ST_TAIL: state_n = ST_IDLE;
			ST_POP: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		d_we    = 1'b0;
		d_waddr = count_q;
		d_wdata = '{prefix: prev_q, suffix: add_c, first: leadp_q};
		d_raddr = '0;
		s_we    = 1'b0;
		s_waddr = depth_q[AW-1:0];
		s_wdata = code_q[7:0];
		s_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				d_raddr = prev_q - FIRST_ENTRY;
				s_raddr = depth_q[AW-1:0] - 1'b1;
				s_we    = lit_push;
				s_waddr = '0;
				s_wdata = code[7:0];
			end
			ST_LEADP: d_raddr = code_q - FIRST_ENTRY;
			ST_LEADC: begin
				d_we    = 1'b1;
				d_raddr = code_q - FIRST_ENTRY;
				s_we    = code_q < FIRST_ENTRY;
				s_waddr = '0;
			end
			ST_UNWIND: begin
				d_raddr = d_rdata.prefix - FIRST_ENTRY;
				s_we    = 1'b1;
				s_wdata = d_rdata.suffix;
			end
			ST_TAIL: begin
				s_we    = 1'b1;
				s_wdata = chain_q[7:0];
			end
			ST_POP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			bits_q  <= '0;
			width_q <= WIDTH_MIN;
			prev_q  <= CODE_CLEAR;
			count_q <= '0;
			end_q   <= 1'b0;
			err_q   <= STAT_OK;
			depth_q <= '0;
			early_q <= 1'b1;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_wen) begin
				early_q <= cfg_wdata;
			end
			if (rv_q && !res_stall) begin
				rv_q <= 1'b0;
			end
			if (go && !pull) begin
				rv_q <= 1'b1;
			end
			if (state_q == ST_POP) begin
				rv_q <= 1'b1;
			end
			if (absorb) begin
				acc_q  <= acc_n;
				bits_q <= cut ? shift : bits_n;
			end
			end_q <= end_n;
			err_q <= err_n;
			if (take && code == CODE_CLEAR) begin
				count_q <= '0;
				width_q <= WIDTH_MIN;
				prev_q  <= CODE_CLEAR;
			end
			if (take && code == CODE_END) begin
				prev_q <= CODE_END;
			end
			if (lit_push) begin
				depth_q <= {{AW{1'b0}}, 1'b1};
				prev_q  <= code;
			end
			if (pull) begin
				depth_q <= depth_q - 1'b1;
			end
			unique case (state_q)
				ST_LEADC: begin
					count_q <= count_q + 1'b1;
					prev_q  <= code_q;
					if (edge_val == EDGE_W10 || edge_val == EDGE_W11 ||
					    edge_val == EDGE_W12) begin
						width_q <= width_q + 1'b1;
					end
					if (code_q < FIRST_ENTRY) begin
						depth_q <= {{AW{1'b0}}, 1'b1};
					end
				end
				ST_UNWIND, ST_TAIL: depth_q <= depth_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (to_leadp) begin
			code_q <= code;
		end
		if (state_q == ST_LEADP) begin
			leadp_q <= lead_prev;
		end
		if (state_q == ST_UNWIND) begin
			chain_q <= d_rdata.prefix;
		end
		if (go && !pull) begin
			ob_q   <= '0;
			ov_q   <= 1'b0;
			last_q <= 1'b0;
			de_q   <= end_n;
			st_q   <= refuse ? STAT_REFUSED : err_n;
		end
		if (state_q == ST_POP) begin
			ob_q   <= s_rdata;
			ov_q   <= 1'b1;
			last_q <= depth_q == '0;
			de_q   <= end_q;
			st_q   <= err_q;
		end
	end

	lzw_dict #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_dict (
		.clk(clk),
		.arst_n(arst_n),
		.we(d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	lzw_stack #(
		.DEPTH(MAX_CODES),
		.AW(AW)
	) u_stack (
		.clk(clk),
		.we(s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	assign res_valid   = rv_q;
	assign out_byte    = ob_q;
	assign out_valid   = ov_q;
	assign string_last = last_q;
	assign data_ended  = de_q;
	assign status      = st_q;

endmodule

### sv/lzw_checker.sv
// port-level checks of the lzw stream decoder, bound to the top level
module lzw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       string_last,
	input logic       data_ended,
	input logic [1:0] status
);
	import lzw_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(status) && $stable(out_byte))
		else $error("stalled result beat changed");

	a_last_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && string_last |-> out_valid)
		else $error("string_last without a decoded byte");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("out_byte not zero on a beat without a byte");

	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && data_ended |=> !res_valid || data_ended)
		else $error("data_ended dropped");

endmodule

bind lzw_stream_decoder lzw_checker u_lzw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.out_byte(out_byte),
	.out_valid(out_valid),
	.string_last(string_last),
	.data_ended(data_ended),
	.status(status)
);
